>>> rtl/kst_pkg.sv
package kst_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int KEY_BYTES_DEF = 32;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TAKEN   = 3'd1;
    localparam logic [2:0] ST_OFF     = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_LEN     = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_DESTROY = 2'd1;

    localparam logic CFG_ENABLE    = 1'b0;
    localparam logic CFG_MAX_SLOTS = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] key_id;
        logic [7:0]  data_byte;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] new_key_id;
        logic [2:0]  status;
        logic        out_last;
    } t_out;

    // search token passed along the chain of slot cells
    typedef struct packed {
        logic found_id;
        logic found_free;
    } t_tok;

    // command to one cell (each cell has its own)
    typedef struct packed {
        logic        set;
        logic        clr;
        logic [31:0] ident;
    } t_cmd;

endpackage

>>> rtl/kst_ram.sv
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/kst_cell.sv
// One key slot: valid bit and identifier tag. Passes a priority token down
// the row so the lowest matching (or free) slot wins.
module kst_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_range,
    input  logic [31:0]   i_key_id,
    input  kst_pkg::t_tok i_tok,
    output kst_pkg::t_tok o_tok,
    output logic          o_hit_id,
    output logic          o_hit_free,
    output logic          o_valid,
    input  kst_pkg::t_cmd i_cmd
);
    logic        r_valid;
    logic [31:0] r_ident;
    logic        match;
    logic        free;

    assign match = i_in_range && r_valid && (r_ident == i_key_id);
    assign free  = i_in_range && !r_valid;
    assign o_hit_id   = match && !i_tok.found_id;
    assign o_hit_free = free && !i_tok.found_free;
    assign o_tok.found_id   = i_tok.found_id || match;
    assign o_tok.found_free = i_tok.found_free || free;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ident <= '0;
        end else if (i_cmd.set) begin
            r_valid <= 1'b1;
            r_ident <= i_cmd.ident;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
            r_ident <= '0;
        end
    end
endmodule

>>> rtl/key_slot_table_xor_cipher.sv
// Key slot table with repeating-key XOR cipher. Each request (start while not
// busy) yields exactly one result, strobed by o_valid (registered from busy) for
// one cycle; the receiver cannot stall, so take every result when strobed.
// Busy covers the merge of the key byte from the registered key memory read,
// addressed by the identifier search along the row of slot cells. Key bytes
// are read only after a complete load marks a slot valid; no clearing pass.
module key_slot_table_xor_cipher #(
    parameter int NUM_SLOTS = kst_pkg::NUM_SLOTS_DEF,
    parameter int KEY_BYTES = kst_pkg::KEY_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kst_pkg::t_in  i_req,
    output logic          o_valid,
    output kst_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [6:0]    i_cfg_data
);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int CW = $clog2(KEY_BYTES + 2);
    localparam int AW = $clog2(NUM_SLOTS * KEY_BYTES);
    localparam int UW = $clog2(NUM_SLOTS + 1);
    localparam int MSR = (NUM_SLOTS < 64) ? NUM_SLOTS : 64;

    logic        r_enable;
    logic [6:0]  r_max_slots;
    logic [31:0] r_next_ident;
    logic [UW-1:0] r_used;
    logic [SW-1:0] r_load_slot;
    logic [CW-1:0] r_load_count;
    logic          r_load_found;
    logic [KW-1:0] r_msg_pos;
    logic          r_busy;
    logic          r_valid;
    kst_pkg::t_in  r_req;
    kst_pkg::t_out r_res;
    logic          r_xor;

    kst_pkg::t_tok tok [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] hit_id, hit_free, cell_valid;
    kst_pkg::t_cmd cmd [NUM_SLOTS];

    logic          accept;
    kst_pkg::t_in  req;
    logic [SW-1:0] id_slot, free_slot;
    logic          id_ok;
    logic [7:0]    key_byte;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [SW-1:0] ld_slot;
    logic          ld_found;
    logic          commit, destroy;

    assign accept = start && !r_busy;
    assign req    = i_req;
    assign busy   = r_busy;
    assign tok[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
            kst_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_in_range(32'(g) < 32'(r_max_slots)),
                .i_key_id  (req.key_id),
                .i_tok     (tok[g]),
                .o_tok     (tok[g+1]),
                .o_hit_id  (hit_id[g]),
                .o_hit_free(hit_free[g]),
                .o_valid   (cell_valid[g]),
                .i_cmd     (cmd[g])
            );
            assign cmd[g].set   = commit && (ld_slot == SW'(g));
            assign cmd[g].clr   = destroy && hit_id[g];
            assign cmd[g].ident = r_next_ident;
        end
    endgenerate

    // encode one-hot winners
    always_comb begin
        id_slot   = '0;
        free_slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (hit_id[i])   id_slot   = SW'(i);
            if (hit_free[i]) free_slot = SW'(i);
        end
    end

    assign id_ok = tok[NUM_SLOTS].found_id && (req.key_id != 32'd0);

    // slot for this load byte: chosen at the first byte
    assign ld_slot  = (r_load_count == '0) ? free_slot : r_load_slot;
    assign ld_found = (r_load_count == '0) ? tok[NUM_SLOTS].found_free : r_load_found;

    logic [CW-1:0] cnt_next;
    assign cnt_next = (r_load_count <= CW'(KEY_BYTES)) ? r_load_count + 1'b1 : r_load_count;

    logic is_load;
    assign is_load = accept && r_enable && (req.req_type == kst_pkg::REQ_LOAD);

    assign commit = is_load && req.last && (cnt_next == CW'(KEY_BYTES))
                    && !(32'(r_used) >= 32'(r_max_slots)) && ld_found
                    && (32'(ld_slot) < 32'(r_max_slots)) && !cell_valid[ld_slot];
    assign destroy = accept && r_enable && (req.req_type == kst_pkg::REQ_DESTROY) && id_ok;

    assign ram_we    = is_load && ld_found && (r_load_count < CW'(KEY_BYTES));
    assign ram_waddr = AW'(ld_slot) * AW'(KEY_BYTES) + AW'(r_load_count);
    assign ram_raddr = AW'(id_slot) * AW'(KEY_BYTES) + AW'(r_msg_pos);

    kst_ram #(.WIDTH(8), .DEPTH(NUM_SLOTS * KEY_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(req.data_byte),
        .i_raddr(ram_raddr),
        .o_rdata(key_byte)
    );

    // config writes, control and state update on accept, key byte merge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_max_slots  <= 7'(MSR);
            r_next_ident <= 32'd1;
            r_used       <= '0;
            r_load_slot  <= '0;
            r_load_count <= '0;
            r_load_found <= 1'b0;
            r_msg_pos    <= '0;
            r_busy       <= 1'b0;
            r_valid      <= 1'b0;
            r_xor        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kst_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    kst_pkg::CFG_MAX_SLOTS: begin
                        if (i_cfg_data != 7'd0 && 32'(i_cfg_data) <= NUM_SLOTS) begin
                            r_max_slots <= i_cfg_data;
                        end
                    end
                    default: ;
                endcase
            end
            r_valid <= r_busy;
            r_busy  <= accept;
            r_xor   <= 1'b0;
            if (accept) begin
                r_req <= req;
                r_res <= '0;
                r_res.out_last <= req.last;
                if (!r_enable) begin
                    r_res.status <= kst_pkg::ST_OFF;
                end else if (req.req_type == kst_pkg::REQ_LOAD) begin
                    r_load_slot  <= ld_slot;
                    r_load_found <= ld_found;
                    r_load_count <= cnt_next;
                    if (!req.last) begin
                        r_res.status <= kst_pkg::ST_TAKEN;
                    end else begin
                        if (cnt_next != CW'(KEY_BYTES)) r_res.status <= kst_pkg::ST_LEN;
                        else if (!commit) r_res.status <= kst_pkg::ST_FULL;
                        else begin
                            r_res.new_key_id <= r_next_ident;
                            r_next_ident <= r_next_ident + 32'd1;
                            r_used <= r_used + 1'b1;
                        end
                        r_load_count <= '0;
                        r_load_found <= 1'b0;
                    end
                end else if (req.req_type == kst_pkg::REQ_DESTROY) begin
                    if (!id_ok) r_res.status <= kst_pkg::ST_UNKNOWN;
                    else if (r_used != '0) r_used <= r_used - 1'b1;
                end else begin
                    if (!id_ok) begin
                        r_res.status <= kst_pkg::ST_UNKNOWN;
                    end else begin
                        r_xor <= 1'b1;
                        r_msg_pos <= (32'(r_msg_pos) + 1 == KEY_BYTES) ? '0
                                     : KW'(r_msg_pos + 1'b1);
                    end
                    if (req.last) r_msg_pos <= '0;
                end
            end
            // merge key byte once the memory read returns
            if (r_xor) begin
                r_res.out_byte <= r_req.data_byte ^ key_byte;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

>>> test/tb_key_slot_table_xor_cipher.sv
module tb_key_slot_table_xor_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = kst_pkg::NUM_SLOTS_DEF;
    localparam int KLEN  = kst_pkg::KEY_BYTES_DEF;
    localparam logic [1:0] REQ_ENC = 2'd2;
    localparam logic [1:0] REQ_DEC = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    kst_pkg::t_in  i_req = '0;
    logic          o_valid;
    kst_pkg::t_out o_res;
    logic          i_cfg_we = 1'b0;
    logic          i_cfg_idx = 1'b0;
    logic [6:0]    i_cfg_data = '0;

    key_slot_table_xor_cipher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_valid(o_valid), .o_res(o_res),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: a private copy of the key table and cipher position.
    logic [7:0]  key_mem [NSLOT*KLEN];
    logic        slot_used [NSLOT];
    logic [31:0] slot_tag [NSLOT];
    logic [31:0] next_tag;
    int unsigned live_keys;
    int unsigned fill_slot;
    int unsigned fill_cnt;
    logic        fill_ok;
    int unsigned cipher_pos;
    logic        run_on;
    int unsigned slot_cap;

    kst_pkg::t_out expected_q[$];
    int          errors = 0;
    longint      cycles = 0;
    // identifiers handed out and still (probably) live, used to aim requests
    logic [31:0] issued_ids[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int find_slot(input logic [31:0] id);
        if (id == 0) return -1;
        for (int i = 0; i < slot_cap; i++)
            if (slot_used[i] && slot_tag[i] == id) return i;
        return -1;
    endfunction

    function automatic kst_pkg::t_out predict_cipher(input kst_pkg::t_in rq);
        kst_pkg::t_out r;
        int   s;
        r = '0;
        r.out_last = rq.last;
        if (!run_on) begin
            r.status = kst_pkg::ST_OFF;
            return r;
        end
        case (rq.req_type)
            kst_pkg::REQ_LOAD: begin
                if (fill_cnt == 0) begin
                    fill_ok = 1'b0;
                    fill_slot = 0;
                    for (int i = 0; i < slot_cap; i++)
                        if (!slot_used[i]) begin
                            fill_slot = i;
                            fill_ok = 1'b1;
                            break;
                        end
                end
                if (fill_ok && fill_cnt < KLEN) key_mem[fill_slot*KLEN + fill_cnt] = rq.data_byte;
                if (fill_cnt <= KLEN) fill_cnt++;
                if (!rq.last) r.status = kst_pkg::ST_TAKEN;
                else begin
                    if (fill_cnt != KLEN) r.status = kst_pkg::ST_LEN;
                    else if (live_keys >= slot_cap || !fill_ok || fill_slot >= slot_cap
                             || slot_used[fill_slot]) r.status = kst_pkg::ST_FULL;
                    else begin
                        slot_used[fill_slot] = 1'b1;
                        slot_tag[fill_slot] = next_tag;
                        r.new_key_id = next_tag;
                        issued_ids.push_back(next_tag);
                        next_tag++;
                        live_keys++;
                    end
                    fill_cnt = 0;
                    fill_ok = 1'b0;
                end
            end
            kst_pkg::REQ_DESTROY: begin
                s = find_slot(rq.key_id);
                if (s < 0) r.status = kst_pkg::ST_UNKNOWN;
                else begin
                    slot_used[s] = 1'b0;
                    slot_tag[s] = '0;
                    if (live_keys > 0) live_keys--;
                end
            end
            default: begin
                s = find_slot(rq.key_id);
                if (s < 0) r.status = kst_pkg::ST_UNKNOWN;
                else begin
                    r.out_byte = rq.data_byte ^ key_mem[s*KLEN + cipher_pos];
                    cipher_pos = (cipher_pos + 1) % KLEN;
                end
                if (rq.last) cipher_pos = 0;
            end
        endcase
        return r;
    endfunction

    // Apply a register write to the block and to the predictor.
    task automatic write_reg(input logic idx, input logic [6:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == kst_pkg::CFG_ENABLE) run_on = val[0];
        else if (val >= 1 && val <= NSLOT) slot_cap = 32'(val);
        @(posedge i_clk);
    endtask

    // Hold off for a random gap: mostly short, now and then long.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        repeat (n) @(posedge i_clk);
    endtask

    // Send one request; the transfer happens at the edge where busy is low.
    task automatic send_req(input logic [1:0] op, input logic [31:0] id,
                            input logic [7:0] data, input logic lst);
        kst_pkg::t_in rq;
        rq = '{req_type: op, key_id: id, data_byte: data, last: lst};
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_q.push_back(predict_cipher(rq));
        start <= 1'b0;
        // busy is high in this cycle anyway
        @(posedge i_clk);
        idle_gap();
    endtask

    // Drain everything in flight before touching registers.
    task automatic wait_drained();
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic load_key(input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_req(kst_pkg::REQ_LOAD, $urandom, 8'($urandom), i == nbytes - 1);
    endtask

    function automatic logic [31:0] pick_id();
        if (issued_ids.size() != 0 && $urandom_range(0, 9) < 8)
            return issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        return ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    endfunction

    task automatic send_message(input logic [31:0] id, input int len);
        for (int i = 0; i < len; i++)
            send_req($urandom_range(0, 1) ? REQ_ENC : REQ_DEC, id, 8'($urandom),
                     i == len - 1);
    endtask

    // Check each result against the oldest prediction.
    always @(posedge i_clk) begin
        kst_pkg::t_out w;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_res.status), 32'd0);
            end else begin
                w = expected_q.pop_front();
                if (o_res.out_byte !== w.out_byte)
                    report_mismatch("out_byte", 32'(o_res.out_byte), 32'(w.out_byte));
                if (o_res.new_key_id !== w.new_key_id)
                    report_mismatch("new_key_id", o_res.new_key_id, w.new_key_id);
                if (o_res.status !== w.status)
                    report_mismatch("status", 32'(o_res.status), 32'(w.status));
                if (o_res.out_last !== w.out_last)
                    report_mismatch("out_last", 32'(o_res.out_last), 32'(w.out_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_key_slot_table_xor_cipher: FAIL");
            $finish;
        end
    end

    // Disabled block: every request type answers not-enabled.
    task automatic test_disabled();
        send_req(kst_pkg::REQ_LOAD, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_req(kst_pkg::REQ_DESTROY, 32'd1, 8'h00, 1'b0);
        send_req(REQ_ENC, 32'd1, 8'hAA, 1'b0);
        send_req(REQ_DEC, 32'd0, 8'h55, 1'b1);
        wait_drained();
        write_reg(kst_pkg::CFG_ENABLE, 7'd1);
    endtask

    // Directed: short and overlong keys, a good key, cipher, destroy, unknowns.
    task automatic test_directed();
        load_key(1);
        load_key(KLEN + 3);
        load_key(KLEN - 1);
        load_key(KLEN);
        send_req(REQ_ENC, 32'd1, 8'h00, 1'b0);
        send_req(REQ_DEC, 32'd1, 8'hFF, 1'b1);
        send_req(REQ_ENC, 32'd0, 8'h12, 1'b1);
        send_req(REQ_DEC, 32'hFFFF_FFFF, 8'h34, 1'b0);
        send_req(kst_pkg::REQ_DESTROY, 32'd0, 8'h00, 1'b0);
        send_req(kst_pkg::REQ_DESTROY, 32'd1, 8'h00, 1'b1);
        send_req(kst_pkg::REQ_DESTROY, 32'd1, 8'h00, 1'b0);
        wait_drained();
    endtask

    // Small table: fill it, overflow it, then shrink below live slots.
    task automatic test_table_full();
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd0);
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd127);
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd2);
        repeat (3) load_key(KLEN);
        wait_drained();
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd1);
        load_key(KLEN);
        send_message(pick_id(), 3);
        wait_drained();
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd64);
    endtask

    // Random: mostly whole key loads and messages on live keys, some noise.
    task automatic test_random(input int items);
        int sent;
        int k;
        sent = 0;
        while (sent < items) begin
            k = $urandom_range(0, 19);
            if (k < 4) begin
                load_key(KLEN);
                sent += KLEN;
            end else if (k < 14) begin
                int len = $urandom_range(1, 40);
                send_message(pick_id(), len);
                sent += len;
            end else if (k < 17) begin
                send_req(kst_pkg::REQ_DESTROY, pick_id(), 8'($urandom),
                         1'($urandom_range(0, 1)));
                sent++;
            end else begin
                send_req(2'($urandom_range(0, 3)), pick_id(), 8'($urandom),
                         1'($urandom_range(0, 1)));
                sent++;
            end
        end
        wait_drained();
    endtask

    // Identifier wrap: jump the counter near 2^32 with a fresh reset-free path
    // is impossible, so exercise high id bits through random lookups instead.
    initial begin
        for (int i = 0; i < NSLOT*KLEN; i++) key_mem[i] = '0;
        for (int i = 0; i < NSLOT; i++) begin
            slot_used[i] = 1'b0;
            slot_tag[i] = '0;
        end
        next_tag = 32'd1;
        live_keys = 0;
        fill_slot = 0;
        fill_cnt = 0;
        fill_ok = 1'b0;
        cipher_pos = 0;
        run_on = 1'b0;
        slot_cap = NSLOT;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled();
        test_directed();
        test_table_full();
        test_random(300);
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd5);
        test_random(150);
        write_reg(kst_pkg::CFG_MAX_SLOTS, 7'd64);
        test_random(250);
        write_reg(kst_pkg::CFG_ENABLE, 7'd0);
        test_random(30);

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_key_slot_table_xor_cipher: PASS");
        end else begin
            $display("tb_key_slot_table_xor_cipher: FAIL");
        end
        $finish;
    end
endmodule
